@@ sv/sha256_pkg.sv @@
// shared constants and types of the sha-256 byte stream hasher
// round constants, initial hash values and the controller/datapath command and status bundles
// no dependencies
package sha256_pkg;

  localparam int HashWords  = 8;
  localparam int BlockBytes = 64;
  localparam int Rounds     = 64;
  localparam int LenPos     = 56;
  localparam int FillW      = 7;
  localparam int MsgW       = 61;
  localparam logic [7:0] PadByte = 8'h80;

  localparam logic [31:0] RoundK [Rounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] InitH [HashWords] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef struct packed {
    logic       absorb;
    logic       pad80;
    logic       pad_zero;
    logic       pad_len;
    logic       start;
    logic       round_en;
    logic [5:0] round;
    logic       update;
    logic       restart;
    logic [2:0] word;
  } sha256_cmd_t;

  typedef struct packed {
    logic fill_is_63;
    logic fill_is_56;
    logic fill_is_64;
  } sha256_sts_t;

endpackage

@@ sv/sha256_in_if.sv @@
// input channel of the hasher: one optional message byte and an end mark per item
// no dependencies
interface sha256_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       msg_end;

  modport source (output valid, data_byte, byte_present, msg_end, input ready);
  modport sink (input valid, data_byte, byte_present, msg_end, output ready);
endinterface

@@ sv/sha256_out_if.sv @@
// output channel of the hasher: one digest word per item
// no dependencies
interface sha256_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_number;
  logic        final_word;

  modport source (output valid, digest_word, word_number, final_word, input ready);
  modport sink (input valid, digest_word, word_number, final_word, output ready);
endinterface

@@ sv/sha256_dp.sv @@
// datapath: block shift register, message schedule window, round unit and chaining words
// depends on sha256_pkg
module sha256_dp (
  input  logic                   clk,
  input  logic                   rst,
  input  sha256_pkg::sha256_cmd_t cmd,
  input  logic [7:0]             data_byte,
  output sha256_pkg::sha256_sts_t sts,
  output logic [31:0]            digest_word
);
  import sha256_pkg::*;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  // byte 0 of the block ends up in the top bits; top word is w[t] during rounds
  logic [8*BlockBytes-1:0] blk;
  logic [FillW-1:0]        fill;
  logic [MsgW-1:0]         msg_bytes;
  logic [31:0]             h [HashWords];
  logic [31:0]             v [HashWords];

  logic [31:0] w0, w1, w9, w14, w_new;
  logic [31:0] s0, s1, ss0, ss1, ch, maj, t1, t2;

  always_comb begin
    w0    = blk[511:480];
    w1    = blk[479:448];
    w9    = blk[223:192];
    w14   = blk[63:32];
    s0    = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
    s1    = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
    w_new = w0 + s0 + w9 + s1;
    ss1   = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
    ss0   = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
    ch    = (v[4] & v[5]) ^ (~v[4] & v[6]);
    maj   = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t1    = v[7] + ss1 + ch + RoundK[cmd.round] + w0;
    t2    = ss0 + maj;
  end

  assign sts.fill_is_63 = (fill == FillW'(BlockBytes - 1));
  assign sts.fill_is_56 = (fill == FillW'(LenPos));
  assign sts.fill_is_64 = (fill == FillW'(BlockBytes));
  assign digest_word    = h[cmd.word];

  always_ff @(posedge clk) begin
    if (cmd.absorb) begin
      blk <= {blk[8*BlockBytes-9:0], data_byte};
    end else if (cmd.pad80) begin
      blk <= {blk[8*BlockBytes-9:0], PadByte};
    end else if (cmd.pad_zero) begin
      blk <= {blk[8*BlockBytes-9:0], 8'h00};
    end else if (cmd.pad_len) begin
      blk <= {blk[8*BlockBytes-65:0], msg_bytes, 3'b000};
    end else if (cmd.round_en) begin
      blk <= {blk[8*BlockBytes-33:0], w_new};
    end

    if (cmd.start) begin
      for (int i = 0; i < HashWords; i++) begin
        v[i] <= h[i];
      end
    end else if (cmd.round_en) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end

    if (rst) begin
      fill      <= '0;
      msg_bytes <= '0;
      for (int i = 0; i < HashWords; i++) begin
        h[i] <= InitH[i];
      end
    end else begin
      if (cmd.absorb || cmd.pad80 || cmd.pad_zero) begin
        fill <= fill + FillW'(1);
      end else if (cmd.pad_len) begin
        fill <= fill + FillW'(8);
      end else if (cmd.update || cmd.restart) begin
        fill <= '0;
      end

      if (cmd.absorb) begin
        msg_bytes <= msg_bytes + MsgW'(1);
      end else if (cmd.restart) begin
        msg_bytes <= '0;
      end

      if (cmd.restart) begin
        for (int i = 0; i < HashWords; i++) begin
          h[i] <= InitH[i];
        end
      end else if (cmd.update) begin
        for (int i = 0; i < HashWords; i++) begin
          h[i] <= h[i] + v[i];
        end
      end
    end
  end

endmodule

@@ sv/sha256_ctrl.sv @@
// controller: byte intake, padding sequence, round count and digest word output
// depends on sha256_pkg
module sha256_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    byte_present,
  input  logic                    msg_end,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [2:0]              word_number,
  output logic                    final_word,
  input  sha256_pkg::sha256_sts_t sts,
  output sha256_pkg::sha256_cmd_t cmd
);
  import sha256_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_PAD80, S_ZERO, S_LEN, S_ROUND, S_UPDATE, S_EMIT
  } state_t;

  state_t     state, state_next;
  state_t     ret, ret_next;
  logic [5:0] round, round_next;
  logic [2:0] word, word_next;
  logic       accept;

  assign in_ready    = (state == S_IDLE);
  assign out_valid   = (state == S_EMIT);
  assign word_number = word;
  assign final_word  = (word == 3'(HashWords - 1));
  assign accept      = in_valid && in_ready;

  always_comb begin
    state_next   = state;
    ret_next     = ret;
    round_next   = round;
    word_next    = word;
    cmd          = '0;
    cmd.round    = round;
    cmd.word     = word;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.absorb = byte_present;
          if (byte_present && sts.fill_is_63) begin
            cmd.start  = 1'b1;
            round_next = '0;
            ret_next   = msg_end ? S_PAD80 : S_IDLE;
            state_next = S_ROUND;
          end else if (msg_end) begin
            state_next = S_PAD80;
          end
        end
      end
      S_PAD80: begin
        cmd.pad80  = 1'b1;
        state_next = S_ZERO;
      end
      S_ZERO: begin
        // past the length slot the block is zero filled to the end and compressed
        if (sts.fill_is_56) begin
          state_next = S_LEN;
        end else if (sts.fill_is_64) begin
          cmd.start  = 1'b1;
          round_next = '0;
          ret_next   = S_ZERO;
          state_next = S_ROUND;
        end else begin
          cmd.pad_zero = 1'b1;
        end
      end
      S_LEN: begin
        cmd.pad_len = 1'b1;
        cmd.start   = 1'b1;
        round_next  = '0;
        ret_next    = S_EMIT;
        state_next  = S_ROUND;
      end
      S_ROUND: begin
        cmd.round_en = 1'b1;
        round_next   = round + 6'd1;
        if (round == 6'(Rounds - 1)) begin
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = ret;
      end
      S_EMIT: begin
        if (out_ready) begin
          word_next = word + 3'd1;
          if (final_word) begin
            cmd.restart = 1'b1;
            state_next  = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret   <= S_IDLE;
      round <= '0;
      word  <= '0;
    end else begin
      state <= state_next;
      ret   <= ret_next;
      round <= round_next;
      word  <= word_next;
    end
  end

endmodule

@@ sv/sha256_byte_stream_hasher.sv @@
// byte items are taken while idle; a full block then holds intake for 64 rounds and one chain update
// end of message: 0x80 byte, zero pad bytes, length, then the rounds and chain update per final
// block (a zero-filled block first if the length slot is passed), then eight digest items, one per
// cycle while taken; intake is held while a block is compressed by the single round unit
// reset: synchronous; chaining words to the initial hash values, counters to zero,
// block buffer is not cleared
module sha256_byte_stream_hasher (
  input  logic         clk,
  input  logic         rst,
  sha256_in_if.sink    msg_in,
  sha256_out_if.source digest_out
);
  import sha256_pkg::*;

  sha256_cmd_t cmd;
  sha256_sts_t sts;

  sha256_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (msg_in.valid),
    .in_ready     (msg_in.ready),
    .byte_present (msg_in.byte_present),
    .msg_end      (msg_in.msg_end),
    .out_valid    (digest_out.valid),
    .out_ready    (digest_out.ready),
    .word_number  (digest_out.word_number),
    .final_word   (digest_out.final_word),
    .sts          (sts),
    .cmd          (cmd)
  );

  sha256_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .data_byte   (msg_in.data_byte),
    .sts         (sts),
    .digest_word (digest_out.digest_word)
  );

`ifndef NO_ASSERTIONS
  // intake stops while a digest is being handed out
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(digest_out.valid && msg_in.ready))
    else $error("input taken while digest pending");

  // digest words leave in order
  a_word_order: assert property (@(posedge clk) disable iff (rst)
    (digest_out.valid && digest_out.ready && !digest_out.final_word) |=>
    (digest_out.valid && digest_out.word_number == 3'($past(digest_out.word_number) + 3'd1)))
    else $error("digest word out of order");

  // after the last word the block returns to intake
  a_back_to_idle: assert property (@(posedge clk) disable iff (rst)
    (digest_out.valid && digest_out.ready && digest_out.final_word) |=>
    (!digest_out.valid && msg_in.ready && digest_out.word_number == 3'd0))
    else $error("no return to intake after digest");
`endif

endmodule
